// ===== design/gwm_pkg.sv =====
// Shared types and constants of the glob wildcard matcher.
package gwm_pkg;

   localparam int PATTERN_MAX = 64;

   localparam logic [7:0] STAR_CH  = 8'h2A;
   localparam logic [7:0] QMARK_CH = 8'h3F;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEXT   = 2'd2,
      FUNC_END    = 2'd3
   } gwm_func_type;

   typedef struct packed {
      logic       clear;
      logic       append;
      logic       text;
      logic       rearm;
      logic [7:0] ch;
   } gwm_op_type;

   typedef struct packed {
      logic used;
      logic eps;
      logic step;
   } gwm_link_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } gwm_rsp_type;

endpackage

// ===== design/gwm_if.sv =====
// Request and response channel interfaces of the glob wildcard matcher.
interface gwm_req_if;
   import gwm_pkg::*;

   logic         valid;
   logic         ready;
   gwm_func_type func;
   logic [7:0]   ch;

   modport source (output valid, output func, output ch, input ready);
   modport sink (input valid, input func, input ch, output ready);
endinterface

interface gwm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflow;

   modport source (output valid, output matched, output overflow, input ready);
   modport sink (input valid, input matched, input overflow, output ready);
endinterface

// ===== design/gwm_cell.sv =====
// One pattern position: stored byte, fill bit and active bit of the matcher chain.
module gwm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gwm_pkg::gwm_op_type   op,
   input  logic                  head,
   input  gwm_pkg::gwm_link_type link_in,
   output gwm_pkg::gwm_link_type link_out,
   output logic                  hit
);
   import gwm_pkg::*;

   logic       act_ff;
   logic       act_in;
   logic       used_ff;
   logic       used_in;
   logic [7:0] pat_ff;
   logic [7:0] pat_in;
   logic       closed;
   logic       is_star;
   logic       is_hit;

   always_comb begin
      closed        = act_ff | link_in.eps;
      is_star       = (pat_ff == STAR_CH);
      is_hit        = (pat_ff == QMARK_CH) || (pat_ff == op.ch);
      link_out.used = used_ff;
      link_out.eps  = closed & used_ff & is_star;
      link_out.step = closed & used_ff & !is_star & is_hit;
      hit           = closed & link_in.used & !used_ff;

      act_in  = act_ff;
      used_in = used_ff;
      pat_in  = pat_ff;
      if (op.rearm) begin
         act_in = head;
      end else if (op.text) begin
         act_in = link_out.eps | link_in.step;
      end
      if (op.clear) begin
         used_in = 1'b0;
      end else if (op.append && link_in.used && !used_ff) begin
         used_in = 1'b1;
         pat_in  = op.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= head;
         used_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
   end

endmodule

// ===== design/glob_wildcard_matcher.sv =====
// Glob wildcard matcher top level: beat decode, cell chain and response skid stage.
//
// The request channel carries one beat per command: clear pattern, append a
// pattern byte, a text byte, or end of text. Pattern bytes fill a chain of
// 64 cells in order; '*' matches any run of bytes, '?' any one byte, and
// every other byte itself. Text bytes advance the active-position vector of
// the whole chain at once, so one beat is taken every cycle while not stalled.
// Only an end-of-text beat gives a response beat: matched and overflow,
// registered into the output register, or the skid while it is held.
// Appending more than 64 bytes sets overflow and forces matched low until
// the next clear. Clear, append and end of text rearm the text to its start.
// A response held by the receiver goes into a one-beat skid register; the
// request side stalls only while both the output and the skid are full.
// Reset empties the pattern, clears overflow and rearms the text; the
// response channel comes up empty.
module glob_wildcard_matcher (
   input logic       clock,
   input logic       reset,
   gwm_req_if.sink   req_bus,
   gwm_rsp_if.source rsp_bus
);
   import gwm_pkg::*;

   gwm_op_type                   op;
   gwm_link_type                 links [0:PATTERN_MAX];
   logic [PATTERN_MAX-1:0]       hits;
   logic                         accept;
   logic                         is_end;
   logic                         act_end_ff;
   logic                         act_end_in;
   logic                         hit_end;
   logic                         ovf_ff;
   logic                         ovf_in;
   gwm_rsp_type                  result;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   gwm_rsp_type                  out_ff;
   gwm_rsp_type                  out_in;
   logic                         skid_valid_ff;
   logic                         skid_valid_in;
   gwm_rsp_type                  skid_ff;
   gwm_rsp_type                  skid_in;
   logic                         pop;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      op     = '0;
      is_end = 1'b0;
      op.ch  = req_bus.ch;
      if (accept) begin
         unique case (req_bus.func)
            FUNC_CLEAR:  op.clear  = 1'b1;
            FUNC_APPEND: op.append = 1'b1;
            FUNC_TEXT:   op.text   = 1'b1;
            FUNC_END:    is_end    = 1'b1;
            default:     op.text   = 1'b0;
         endcase
      end
      op.rearm = op.clear | op.append | is_end;
   end

   assign links[0] = '{used: 1'b1, eps: 1'b0, step: 1'b0};

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      gwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .op       (op),
         .head     (i == 0),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .hit      (hits[i])
      );
   end

   always_comb begin
      hit_end = (act_end_ff | links[PATTERN_MAX].eps) & links[PATTERN_MAX].used;

      act_end_in = act_end_ff;
      if (op.rearm) begin
         act_end_in = 1'b0;
      end else if (op.text) begin
         act_end_in = links[PATTERN_MAX].step;
      end

      ovf_in = ovf_ff;
      if (op.clear) begin
         ovf_in = 1'b0;
      end else if (op.append && links[PATTERN_MAX].used) begin
         ovf_in = 1'b1;
      end

      result.matched  = ((|hits) | hit_end) & !ovf_ff;
      result.overflow = ovf_ff;
   end

   // hold a stalled response in the skid register, advance it when the output drains
   always_comb begin
      pop           = out_valid_ff && rsp_bus.ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (is_end) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_end_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         act_end_ff    <= act_end_in;
         ovf_ff        <= ovf_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.matched  = out_ff.matched;
   assign rsp_bus.overflow = out_ff.overflow;

endmodule
